>>> hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: field widths,
// character codes, operation codes and the result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	// field widths of the item ports
	localparam int CELL_W = 16;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CODE_W = 8;

	// screen cell contents
	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
	localparam logic [7:0]        TEXT_ATTR  = 8'h07;

	// character codes with a meaning of their own
	localparam logic [CODE_W-1:0] CH_NUL     = 8'd0;
	localparam logic [CODE_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CODE_W-1:0] CH_RETURN  = 8'd13;

	// operation codes
	localparam logic FUNC_PUT  = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	// one result from the controller to the output stage
	typedef struct packed {
		logic [CELL_W-1:0] cell_value;
		logic [ROW_W-1:0]  cursor_row;
		logic [COL_W-1:0]  cursor_col;
	} tcw_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/tcw_screen_ram.sv
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_screen_ram
	import tcw_pkg::*;
#(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire logic [CELL_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [AW-1:0]     rd_addr,
	output logic      [CELL_W-1:0] rd_data
);

	logic [CELL_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Console sequencer: clears the screen after reset, decodes each item,
// streams the scroll copy through the screen store, writes characters and
// moves the cursor.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	parameter int AW      = 11
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// item side
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              func,
	input  wire logic [CODE_W-1:0] char_code,
	input  wire logic [ROW_W-1:0]  cell_row,
	input  wire logic [COL_W-1:0]  cell_col,
	// result side
	output logic                   res_load,
	input  wire logic              res_ready,
	output tcw_res_t               res,
	// screen store
	output logic                   mem_wr_en,
	output logic      [AW-1:0]     mem_wr_addr,
	output logic      [CELL_W-1:0] mem_wr_data,
	output logic                   mem_rd_en,
	output logic      [AW-1:0]     mem_rd_addr,
	input  wire logic [CELL_W-1:0] mem_rd_data
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int RW    = $clog2(ROWS + 1);
	localparam int CW    = $clog2(COLUMNS);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCROLL,
		ST_FILL,
		ST_PUT,
		ST_READ,
		ST_NOP
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     cnt_q;
	logic [RW-1:0]     row_q;
	logic [CW-1:0]     col_q;
	logic [CODE_W-1:0] code_q;
	logic              cp_valid_s1;
	logic [AW-1:0]     cp_addr_s1;

	logic              accept;
	logic              rd_in_range;
	logic [AW-1:0]     rd_addr_in;
	logic [AW-1:0]     put_addr;
	logic [CW:0]       col_inc;
	logic              col_wrap;
	logic              put_store;
	logic [RW-1:0]     next_row;
	logic [CW-1:0]     next_col;
	logic [RW-1:0]     res_row;
	logic [CW-1:0]     res_col;
	logic [RW+ROW_W-1:0] row_ext;
	logic [CW+COL_W-1:0] col_ext;
	logic              cnt_last;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign cnt_last = (cnt_q == AW'(CELLS - 1));

	// read address from the item fields
	assign rd_in_range = (32'(cell_row) < ROWS) && (32'(cell_col) < COLUMNS);
	assign rd_addr_in  = AW'(32'(cell_row) * COLUMNS + 32'(cell_col));

	// character write and cursor advance
	assign put_addr = AW'(32'(row_q) * COLUMNS + 32'(col_q));
	assign col_inc  = {1'b0, col_q} + (CW+1)'(1);
	assign col_wrap = (col_inc == (CW+1)'(COLUMNS));

	always_comb begin
		next_row  = row_q;
		next_col  = col_q;
		put_store = 1'b0;
		case (code_q)
			CH_NEWLINE: begin
				next_row = row_q + RW'(1);
				next_col = '0;
			end
			CH_RETURN: begin
				next_row = row_q;
			end
			default: begin
				put_store = 1'b1;
				if (col_wrap) begin
					next_row = row_q + RW'(1);
					next_col = '0;
				end else begin
					next_col = col_inc[CW-1:0];
				end
			end
		endcase
	end

	// result bundle
	assign res_load = res_ready &&
		((state_q == ST_PUT) || (state_q == ST_READ) || (state_q == ST_NOP));
	assign res_row  = (state_q == ST_PUT) ? next_row : row_q;
	assign res_col  = (state_q == ST_PUT) ? next_col : col_q;
	assign row_ext  = {{ROW_W{1'b0}}, res_row};
	assign col_ext  = {{COL_W{1'b0}}, res_col};

	always_comb begin
		res.cell_value = (state_q == ST_READ) ? mem_rd_data : '0;
		res.cursor_row = row_ext[ROW_W-1:0];
		res.cursor_col = col_ext[COL_W-1:0];
	end

	// screen store port steering
	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = cnt_q;
		mem_wr_data = BLANK_CELL;
		mem_rd_en   = 1'b0;
		mem_rd_addr = cnt_q;
		case (state_q)
			ST_CLEAR: begin
				mem_wr_en = 1'b1;
			end
			ST_IDLE: begin
				mem_rd_en   = accept && (func == FUNC_READ) && rd_in_range;
				mem_rd_addr = rd_addr_in;
			end
			ST_SCROLL: begin
				mem_rd_en = 1'b1;
			end
			ST_FILL: begin
				mem_wr_en = !cp_valid_s1;
			end
			ST_PUT: begin
				mem_wr_en   = res_ready && put_store;
				mem_wr_addr = put_addr;
				mem_wr_data = {TEXT_ATTR, code_q};
			end
			default: begin
				mem_wr_en = 1'b0;
			end
		endcase
		// copy write one row up, in the cycle after its read
		if (cp_valid_s1) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = cp_addr_s1;
			mem_wr_data = mem_rd_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			row_q       <= RW'(1);
			col_q       <= '0;
			code_q      <= '0;
			cp_valid_s1 <= 1'b0;
			cp_addr_s1  <= '0;
		end else begin
			cp_valid_s1 <= (state_q == ST_SCROLL);
			cp_addr_s1  <= cnt_q - AW'(COLUMNS);
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						code_q <= char_code;
						if (func == FUNC_READ) begin
							state_q <= rd_in_range ? ST_READ : ST_NOP;
						end else if (char_code == CH_NUL) begin
							state_q <= ST_NOP;
						end else if (row_q >= RW'(ROWS)) begin
							state_q <= ST_SCROLL;
							cnt_q   <= AW'(COLUMNS);
						end else begin
							state_q <= ST_PUT;
						end
					end
				end
				ST_SCROLL: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_last) begin
						state_q <= ST_FILL;
						cnt_q   <= AW'(CELLS - COLUMNS);
					end
				end
				ST_FILL: begin
					if (!cp_valid_s1) begin
						cnt_q <= cnt_q + AW'(1);
						if (cnt_last) begin
							row_q   <= RW'(ROWS - 1);
							state_q <= ST_PUT;
						end
					end
				end
				ST_PUT: begin
					if (res_ready) begin
						row_q   <= next_row;
						col_q   <= next_col;
						state_q <= ST_IDLE;
					end
				end
				ST_READ, ST_NOP: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/text_console_writer.sv
// An accepted item moves the sequencer to its put, read or no-op state and
// its result is loaded into the output register once that register is free;
// in_ready stays low until then. A character that finds a scroll pending
// first copies each row one row up and blanks the last row, one cell per
// cycle through the single write port. After reset the screen store is
// cleared to blanks, with in_ready low; cursor starts at row 1, column 0.
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console with scroll-up, cell read-back and a
// registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              func,
	input  wire logic [CODE_W-1:0] char_code,
	input  wire logic [ROW_W-1:0]  cell_row,
	input  wire logic [COL_W-1:0]  cell_col,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [CELL_W-1:0] cell_value,
	output logic      [ROW_W-1:0]  cursor_row,
	output logic      [COL_W-1:0]  cursor_col
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);

	logic              res_load;
	logic              res_ready;
	tcw_res_t          res;
	logic              mem_wr_en;
	logic [AW-1:0]     mem_wr_addr;
	logic [CELL_W-1:0] mem_wr_data;
	logic              mem_rd_en;
	logic [AW-1:0]     mem_rd_addr;
	logic [CELL_W-1:0] mem_rd_data;
	logic              out_valid_q;

	tcw_ctrl #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.AW      (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.char_code   (char_code),
		.cell_row    (cell_row),
		.cell_col    (cell_col),
		.res_load    (res_load),
		.res_ready   (res_ready),
		.res         (res),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	tcw_screen_ram #(
		.DEPTH (CELLS),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// output register, free when empty or its transfer completes
	assign res_ready = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			cell_value <= res.cell_value;
			cursor_row <= res.cursor_row;
			cursor_col <= res.cursor_col;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_checker
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              func,
	input wire logic [CODE_W-1:0] char_code,
	input wire logic [ROW_W-1:0]  cell_row,
	input wire logic [COL_W-1:0]  cell_col,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [CELL_W-1:0] cell_value,
	input wire logic [ROW_W-1:0]  cursor_row,
	input wire logic [COL_W-1:0]  cursor_col
);

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cell_value) &&
		$stable(cursor_row) && $stable(cursor_col))
		else $error("result changed while stalled");

	// one item at a time: ready drops after each transfer in
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken before the first finished");

	// reported column stays on the screen
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(cursor_col) < COLUMNS))
		else $error("cursor column beyond the last column");

	// reported row is at most one past the last row
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ROWS > 31) || (32'(cursor_row) <= ROWS))
		else $error("cursor row beyond the pending-scroll row");

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcw_checker (.*);

`default_nettype wire

>>> bench/tb_text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Self-checking bench for the text console writer: queued put and read
// transfers go through a valid/ready driver with random gaps. Each transfer
// is predicted on a local screen mirror with cursor and scroll-up handling.
// Each result is compared field by field in arrival order.
// ----------------------------------------------------------------------------

module tb_text_console_writer;
	import tcw_pkg::*;

	localparam int SCR_COLS    = 80;
	localparam int SCR_ROWS    = 25;
	localparam int SCR_CELLS   = SCR_COLS * SCR_ROWS;
	localparam int ITEM_TARGET = 1850;
	localparam int STALL_LIMIT = 20000;
	localparam int TAIL_CYCLES = 8;
	localparam int ERR_SHOW    = 100;

	typedef struct {
		logic              func;
		logic [CODE_W-1:0] code;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
	} console_req_t;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic              in_ready;
	logic              func       = FUNC_PUT;
	logic [CODE_W-1:0] char_code  = '0;
	logic [ROW_W-1:0]  cell_row   = '0;
	logic [COL_W-1:0]  cell_col   = '0;
	logic              out_valid;
	logic              out_ready  = 1'b0;
	logic [CELL_W-1:0] cell_value;
	logic [ROW_W-1:0]  cursor_row;
	logic [COL_W-1:0]  cursor_col;

	// pending requests, expected cell/cursor views, screen mirror
	console_req_t      console_reqs[$];
	tcw_res_t          console_views[$];
	logic [CELL_W-1:0] screen_mirror[SCR_CELLS];
	int                mirror_row;
	int                mirror_col;

	int  live_reqs   = 0;
	int  in_drv_cnt  = 0;
	int  in_acc_cnt  = 0;
	int  err_cnt     = 0;
	int  idle_cycles = 0;
	int  tx_wait     = 0;
	int  rx_wait     = 0;
	bit  tx_calm     = 1'b0;
	bit  rx_calm     = 1'b0;

	text_console_writer #(
		.COLUMNS(SCR_COLS),
		.ROWS   (SCR_ROWS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.char_code (char_code),
		.cell_row  (cell_row),
		.cell_col  (cell_col),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cell_value(cell_value),
		.cursor_row(cursor_row),
		.cursor_col(cursor_col)
	);

	always #5 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic void queue_req(logic f, logic [CODE_W-1:0] code,
			logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
		console_req_t req;
		req.func = f;
		req.code = code;
		req.row  = row;
		req.col  = col;
		console_reqs.push_back(req);
		// NUL puts leave the block untouched, so they do not count
		if (!(f == FUNC_PUT && code == CH_NUL))
			live_reqs++;
	endfunction

	// mostly in range, a share near the bottom rows, some over the full fields
	function automatic void queue_random_read();
		int r;
		r = $urandom_range(0, 19);
		if (r < 11)
			queue_req(FUNC_READ, CODE_W'($urandom_range(0, 255)),
				ROW_W'($urandom_range(0, SCR_ROWS - 1)),
				COL_W'($urandom_range(0, SCR_COLS - 1)));
		else if (r < 16)
			queue_req(FUNC_READ, CODE_W'($urandom_range(0, 255)),
				ROW_W'($urandom_range(SCR_ROWS - 3, SCR_ROWS - 1)),
				COL_W'($urandom_range(0, SCR_COLS - 1)));
		else
			queue_req(FUNC_READ, CODE_W'($urandom_range(0, 255)),
				ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
	endfunction

	// printable text mostly, any nonzero byte otherwise
	function automatic logic [CODE_W-1:0] text_char();
		if ($urandom_range(0, 4) != 0)
			return CODE_W'($urandom_range(8'h20, 8'h7E));
		return CODE_W'($urandom_range(1, 255));
	endfunction

	// apply one transfer to the mirror and return the view it produces
	function automatic tcw_res_t console_advance(console_req_t req);
		tcw_res_t view;
		int       i;
		int       col;
		view = '0;
		if (req.func == FUNC_PUT) begin
			if (req.code != CH_NUL) begin
				// a pending scroll is done before the character
				if (mirror_row >= SCR_ROWS) begin
					for (i = 0; i < SCR_CELLS - SCR_COLS; i++)
						screen_mirror[i] = screen_mirror[i + SCR_COLS];
					for (i = SCR_CELLS - SCR_COLS; i < SCR_CELLS; i++)
						screen_mirror[i] = BLANK_CELL;
					mirror_row = SCR_ROWS - 1;
				end
				if (req.code == CH_NEWLINE) begin
					mirror_col = 0;
					mirror_row++;
				end else if (req.code != CH_RETURN) begin
					col = (mirror_col >= SCR_COLS) ? SCR_COLS - 1 : mirror_col;
					screen_mirror[mirror_row * SCR_COLS + col] = {TEXT_ATTR, req.code};
					mirror_col = col + 1;
					if (mirror_col >= SCR_COLS) begin
						mirror_col = 0;
						mirror_row++;
					end
				end
			end
		end else if (int'(req.row) < SCR_ROWS && int'(req.col) < SCR_COLS) begin
			view.cell_value = screen_mirror[int'(req.row) * SCR_COLS + int'(req.col)];
		end
		view.cursor_row = ROW_W'(mirror_row);
		view.cursor_col = COL_W'(mirror_col);
		return view;
	endfunction

	// input driver: next request after the current transfer and its gap
	always @(negedge clk) begin : console_driver
		console_req_t req;
		logic         nv;
		nv = in_valid;
		if (arst_n) begin
			if (in_valid && in_acc_cnt == in_drv_cnt) begin
				nv = 1'b0;
				if ($urandom_range(0, 63) == 0)
					tx_calm = !tx_calm;
				tx_wait = tx_calm ? 0 : pick_gap();
			end
			if (!nv) begin
				if (tx_wait > 0) begin
					tx_wait--;
				end else if (console_reqs.size() > 0) begin
					req = console_reqs.pop_front();
					func      <= req.func;
					char_code <= req.code;
					cell_row  <= req.row;
					cell_col  <= req.col;
					nv = 1'b1;
					in_drv_cnt++;
				end
			end
		end
		in_valid <= nv;
	end

	// output side stalls
	always @(negedge clk) begin : result_pacer
		if (rx_wait > 0) begin
			rx_wait--;
			out_ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 63) == 0)
				rx_calm = !rx_calm;
			rx_wait = (!rx_calm && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
			out_ready <= (rx_wait == 0);
		end
	end

	// monitor: predict on input transfers, compare output transfers, watchdog
	always @(posedge clk) begin : console_monitor
		tcw_res_t want;
		if (arst_n && in_valid && in_ready) begin
			console_views.push_back(console_advance(
				console_req_t'{func, char_code, cell_row, cell_col}));
			in_acc_cnt++;
		end
		if (arst_n && out_valid && out_ready) begin
			if (console_views.size() == 0) begin
				if (err_cnt < ERR_SHOW)
					$error("result with nothing expected: cell_value %h row %0d col %0d",
						cell_value, cursor_row, cursor_col);
				err_cnt++;
			end else begin
				want = console_views.pop_front();
				if (cell_value !== want.cell_value) begin
					if (err_cnt < ERR_SHOW)
						$error("cell_value: expected %h, actual %h", want.cell_value, cell_value);
					err_cnt++;
				end
				if (cursor_row !== want.cursor_row) begin
					if (err_cnt < ERR_SHOW)
						$error("cursor_row: expected %0d, actual %0d", want.cursor_row,
							cursor_row);
					err_cnt++;
				end
				if (cursor_col !== want.cursor_col) begin
					if (err_cnt < ERR_SHOW)
						$error("cursor_col: expected %0d, actual %0d", want.cursor_col,
							cursor_col);
					err_cnt++;
				end
			end
		end
		// watchdog on cycles without any transfer
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", idle_cycles);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin : console_stimulus
		int k;
		int n;
		int len;
		int pick;
		int req_total;

		// mirror matches the block after its reset clear
		for (k = 0; k < SCR_CELLS; k++)
			screen_mirror[k] = BLANK_CELL;
		mirror_row = 1;
		mirror_col = 0;

		// directed: blank read, NUL, high codes, carriage return, range edges
		queue_req(FUNC_READ, 8'hFF, 5'd0, 7'd0);
		queue_req(FUNC_PUT, CH_NUL, '1, '1);
		queue_req(FUNC_PUT, 8'h41, '0, '0);
		queue_req(FUNC_PUT, 8'hFF, '1, '0);
		queue_req(FUNC_PUT, 8'h80, '0, '1);
		queue_req(FUNC_PUT, 8'h01, '1, '1);
		queue_req(FUNC_PUT, CH_RETURN, '0, '0);
		queue_req(FUNC_READ, 8'h00, 5'd1, 7'd0);
		queue_req(FUNC_READ, 8'h00, 5'd1, 7'd1);
		queue_req(FUNC_READ, 8'h00, 5'd1, 7'd2);
		queue_req(FUNC_READ, 8'h00, 5'd1, 7'd3);
		queue_req(FUNC_READ, 8'h00, 5'd1, 7'd4);
		queue_req(FUNC_READ, 8'h00, 5'd24, 7'd79);
		queue_req(FUNC_READ, 8'h00, '1, '1);
		queue_req(FUNC_READ, 8'h00, 5'd25, 7'd0);
		queue_req(FUNC_READ, 8'h00, 5'd0, 7'd80);
		queue_req(FUNC_PUT, CH_NEWLINE, '0, '0);
		queue_req(FUNC_PUT, 8'h5A, '0, '0);
		queue_req(FUNC_READ, 8'h00, 5'd2, 7'd0);

		// random: lines of text with reads, read bursts, noise, newline runs
		while (live_reqs < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				// one line, sometimes right at or beyond the row width
				n = $urandom_range(0, 9);
				if (n < 6)
					len = $urandom_range(0, 24);
				else if (n < 8)
					len = $urandom_range(SCR_COLS - 2, SCR_COLS + 1);
				else
					len = $urandom_range(SCR_COLS + 2, 2 * SCR_COLS + 10);
				for (k = 0; k < len; k++) begin
					queue_req(FUNC_PUT, text_char(), ROW_W'($urandom_range(0, 31)),
						COL_W'($urandom_range(0, 127)));
					if ($urandom_range(0, 7) == 0)
						queue_random_read();
				end
				n = $urandom_range(0, 19);
				if (n < 3)
					queue_req(FUNC_PUT, CH_RETURN, ROW_W'($urandom_range(0, 31)),
						COL_W'($urandom_range(0, 127)));
				if (n < 17)
					queue_req(FUNC_PUT, CH_NEWLINE, ROW_W'($urandom_range(0, 31)),
						COL_W'($urandom_range(0, 127)));
			end else if (pick < 80) begin
				n = $urandom_range(1, 6);
				repeat (n) queue_random_read();
			end else if (pick < 92) begin
				queue_req(FUNC_PUT, CODE_W'($urandom_range(0, 255)),
					ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
			end else begin
				// newline run, then something that meets a pending scroll
				n = $urandom_range(1, 12);
				repeat (n) queue_req(FUNC_PUT, CH_NEWLINE, '0, '0);
				case ($urandom_range(0, 3))
					0: queue_req(FUNC_PUT, CH_NUL, '0, '0);
					1: queue_req(FUNC_PUT, CH_RETURN, '0, '0);
					2: queue_random_read();
					default: queue_req(FUNC_PUT, text_char(), '0, '0);
				endcase
			end
		end
		req_total = console_reqs.size();

		// reset, then the block clears its screen store on its own
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (in_acc_cnt < req_total || console_views.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (err_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
